FILE: hdl/slot_property_store_unit_assert.svh
// assertion macros shared by the slot property store checks
`ifndef SLOT_PROPERTY_STORE_UNIT_ASSERT_SVH
`define SLOT_PROPERTY_STORE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot property store check failed");

// next-cycle implication, disabled while in reset
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot property store check failed");

`endif

FILE: hdl/sps_pkg.sv
// types and constants for the slot property store
`default_nettype none
package sps_pkg;

	localparam int DEF_SLOT_COUNT   = 256;
	localparam int DEF_PRIMARY_WAYS = 8;
	localparam int DEF_SPILL_WAYS   = 8;

	localparam logic [15:0] RESERVED_ID = 16'hFFFF;

	typedef enum logic [1:0] {
		FUNC_GET   = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_ALLOC = 2'd2,
		FUNC_FREE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_DROPPED = 2'd2,
		ST_NO_SLOT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         slot;
		logic [15:0]        prop_id;
		logic signed [31:0] write_value;
		logic [15:0]        entity_id;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [7:0]         slot_out;
		logic [1:0]         status;
		logic [8:0]         live_slots;
	} rsp_t;

endpackage
`default_nettype wire

FILE: hdl/slot_property_store_unit.sv
// Slot property store: each request is handled in a read step, the synchronous
// read of the addressed slot's primary and spill rows (and the free stack top),
// and an execute step that compares all ways in parallel and writes the row
// back. A new request is taken while the previous word still waits on the
// response side. After reset a clearing pass zeroes the row fill counts; no
// request is taken during it.
`default_nettype none
module slot_property_store_unit #(
	parameter int SLOT_COUNT   = sps_pkg::DEF_SLOT_COUNT,
	parameter int PRIMARY_WAYS = sps_pkg::DEF_PRIMARY_WAYS,
	parameter int SPILL_WAYS   = sps_pkg::DEF_SPILL_WAYS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sps_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sps_pkg::rsp_t rsp
);
	import sps_pkg::*;

	localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW  = $clog2(SLOT_COUNT + 1);
	localparam int PFW = $clog2(PRIMARY_WAYS + 1);
	localparam int SFW = $clog2(SPILL_WAYS + 1);
	localparam int PRW = PFW + PRIMARY_WAYS * 48;
	localparam int SRW = SFW + SPILL_WAYS * 48;

	// row memories: {fill, values, ids}
	logic [PRW-1:0] prow_mem [SLOT_COUNT];
	logic [SRW-1:0] srow_mem [SLOT_COUNT];
	logic [IW-1:0]  fstk_mem [SLOT_COUNT];

	state_t state_q, state_d;
	logic [IW-1:0] clr_q;
	logic [CW-1:0] free_top_q, fresh_q, live_q;
	req_t req_q;
	logic [PRW-1:0] prow_s1;
	logic [SRW-1:0] srow_s1;
	logic [IW-1:0]  fstk_s1;

	logic accept, go;
	logic [IW-1:0] req_idx, pop_idx;

	// write port controls
	logic           row_we;
	logic [IW-1:0]  row_wa;
	logic [PRW-1:0] prow_wd;
	logic [SRW-1:0] srow_wd;
	logic           fstk_we;
	logic [IW-1:0]  fstk_wa;

	logic [CW-1:0] free_top_d, fresh_d, live_d;
	rsp_t res;

	// unpacked read rows
	logic [PFW-1:0] pfill;
	logic [SFW-1:0] sfill;
	logic [PRIMARY_WAYS-1:0][31:0] pvals, pvals_n;
	logic [PRIMARY_WAYS-1:0][15:0] pids, pids_n;
	logic [SPILL_WAYS-1:0][31:0]   svals, svals_n;
	logic [SPILL_WAYS-1:0][15:0]   sids, sids_n;

	assign {pfill, pvals, pids} = prow_s1;
	assign {sfill, svals, sids} = srow_s1;

	// keep reading the held request's slot while the result waits
	assign req_idx   = accept ? IW'(req.slot) : IW'(req_q.slot);
	assign pop_idx   = IW'(free_top_q - CW'(1));
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign go        = (state_q == S_EXEC) && (!rsp_valid || !rsp_stall);

	// synchronous memories
	always_ff @(posedge clk) begin
		if (row_we) begin
			prow_mem[row_wa] <= prow_wd;
			srow_mem[row_wa] <= srow_wd;
		end
		if (fstk_we) begin
			fstk_mem[fstk_wa] <= IW'(req_q.slot);
		end
		prow_s1 <= prow_mem[req_idx];
		srow_s1 <= srow_mem[req_idx];
		fstk_s1 <= fstk_mem[pop_idx];
	end

	// request register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// execute: compare ways, build writeback and result
	always_comb begin
		logic ok_key, in_range, phit, shit, have_free, got, free_ok;
		logic [31:0] pv, sv;
		logic [IW-1:0] new_slot;
		logic [PFW-1:0] pfill_n;
		logic [SFW-1:0] sfill_n;
		in_range = (32'(req_q.slot) < SLOT_COUNT);
		ok_key   = in_range && (req_q.prop_id != RESERVED_ID);
		phit = 1'b0;
		shit = 1'b0;
		pv = '0;
		sv = '0;
		pids_n  = pids;
		pvals_n = pvals;
		sids_n  = sids;
		svals_n = svals;
		pfill_n = pfill;
		sfill_n = sfill;
		// lowest-numbered match wins: scan from the top down
		for (int i = PRIMARY_WAYS - 1; i >= 0; i--) begin
			if (PFW'(i) < pfill && pids[i] == req_q.prop_id) begin
				phit = 1'b1;
				pv   = pvals[i];
			end
		end
		for (int i = SPILL_WAYS - 1; i >= 0; i--) begin
			if (SFW'(i) < sfill && sids[i] == req_q.prop_id) begin
				shit = 1'b1;
				sv   = svals[i];
			end
		end
		// set: update in place or append
		for (int i = 0; i < PRIMARY_WAYS; i++) begin
			if (PFW'(i) < pfill && pids[i] == req_q.prop_id) begin
				pvals_n[i] = req_q.write_value;
			end
			if (!phit && !shit && PFW'(i) == pfill) begin
				pids_n[i]  = req_q.prop_id;
				pvals_n[i] = req_q.write_value;
			end
		end
		for (int i = 0; i < SPILL_WAYS; i++) begin
			if (!phit && SFW'(i) < sfill && sids[i] == req_q.prop_id) begin
				svals_n[i] = req_q.write_value;
			end
			if (!phit && !shit && pfill == PFW'(PRIMARY_WAYS) && SFW'(i) == sfill) begin
				sids_n[i]  = req_q.prop_id;
				svals_n[i] = req_q.write_value;
			end
		end
		if (!phit && !shit) begin
			if (pfill < PFW'(PRIMARY_WAYS)) begin
				pfill_n = pfill + PFW'(1);
			end else if (sfill < SFW'(SPILL_WAYS)) begin
				sfill_n = sfill + SFW'(1);
			end
		end

		have_free = (free_top_q != '0);
		got       = have_free || (fresh_q < CW'(SLOT_COUNT));
		new_slot  = have_free ? fstk_s1 : IW'(fresh_q);
		free_ok   = in_range && (live_q != '0) && (free_top_q < CW'(SLOT_COUNT));

		row_we     = 1'b0;
		row_wa     = IW'(req_q.slot);
		prow_wd    = {pfill_n, pvals_n, pids_n};
		srow_wd    = {sfill_n, svals_n, sids_n};
		fstk_we    = 1'b0;
		fstk_wa    = IW'(free_top_q);
		free_top_d = free_top_q;
		fresh_d    = fresh_q;
		live_d     = live_q;
		res.read_value = '0;
		res.slot_out   = req_q.slot;
		res.status     = ST_OK;

		case (req_q.func)
			FUNC_GET: begin
				if (ok_key && (phit || shit)) begin
					res.read_value = phit ? pv : sv;
				end else begin
					res.status = ST_ABSENT;
				end
			end
			FUNC_SET: begin
				if (ok_key && (phit || shit || pfill < PFW'(PRIMARY_WAYS)
						|| sfill < SFW'(SPILL_WAYS))) begin
					row_we = go;
				end else begin
					res.status = ST_DROPPED;
				end
			end
			FUNC_ALLOC: begin
				if (got) begin
					row_we  = go;
					row_wa  = new_slot;
					prow_wd = '0;
					srow_wd = '0;
					if (have_free) begin
						free_top_d = free_top_q - CW'(1);
					end else begin
						fresh_d = fresh_q + CW'(1);
					end
					live_d       = live_q + CW'(1);
					res.slot_out = 8'(new_slot);
				end else begin
					res.slot_out = '0;
					res.status   = ST_NO_SLOT;
				end
			end
			default: begin
				if (free_ok) begin
					row_we     = go;
					prow_wd    = '0;
					srow_wd    = '0;
					fstk_we    = go;
					free_top_d = free_top_q + CW'(1);
					live_d     = live_q - CW'(1);
				end
			end
		endcase
		res.live_slots = 9'(live_d);

		// clearing pass owns the row write port
		if (state_q == S_CLEAR) begin
			row_we  = 1'b1;
			row_wa  = clr_q;
			prow_wd = '0;
			srow_wd = '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == IW'(SLOT_COUNT - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  if (go) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// counters and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			free_top_q <= '0;
			fresh_q    <= '0;
			live_q     <= '0;
			rsp_valid  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (go) begin
				free_top_q <= free_top_d;
				fresh_q    <= fresh_d;
				live_q     <= live_d;
				rsp_valid  <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp <= res;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sps_check.sv
// port-level checks for the slot property store, bound into slot_property_store_unit
`default_nettype none
`include "slot_property_store_unit_assert.svh"
module sps_check #(
	parameter int SLOT_COUNT = sps_pkg::DEF_SLOT_COUNT
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire sps_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire sps_pkg::rsp_t rsp
);
	import sps_pkg::*;

	// a stalled response word is held
	`SPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// one request at a time: an accepted word closes the request side
	`SPS_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
	// live count never exceeds the slot count
	`SPS_ASSERT_NOW(a_live_bound, rsp_valid, 32'(rsp.live_slots) <= SLOT_COUNT)
	// a nonzero value only comes with an ok status
	`SPS_ASSERT_NOW(a_value_ok, rsp_valid && rsp.read_value != 0, rsp.status == ST_OK)

endmodule

bind slot_property_store_unit sps_check #(.SLOT_COUNT(SLOT_COUNT)) u_sps_check (.*);
`default_nettype wire

FILE: tb/sv/slot_property_store_unit_test.sv
// testbench for the slot property store: directed and random requests checked by a predictor
`default_nettype none
module slot_property_store_unit_test;
	import sps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = DEF_SLOT_COUNT;
	localparam int PWAYS      = DEF_PRIMARY_WAYS;
	localparam int SWAYS      = DEF_SPILL_WAYS;
	localparam int IDLE_LIMIT = 5000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	slot_property_store_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted store contents
	logic [15:0] prim_ids [SLOTS][PWAYS];
	logic [31:0] prim_vals[SLOTS][PWAYS];
	int          prim_fill[SLOTS];
	logic [15:0] spill_ids [SLOTS][SWAYS];
	logic [31:0] spill_vals[SLOTS][SWAYS];
	int          spill_fill[SLOTS];
	logic [7:0]  free_slots[SLOTS];
	int          free_top;
	int          fresh_next;
	int          live_count;

	rsp_t pending_rsp[$];
	int   mismatches = 0;
	bit   no_idle = 1'b0;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	// compute the response word and update the predicted store
	function automatic rsp_t predict_store(req_t w);
		rsp_t r;
		bit   hit;
		int   s;
		bit   got;
		r.read_value = '0;
		r.slot_out = w.slot;
		r.status = ST_OK;
		s = w.slot;
		hit = 1'b0;
		got = 1'b0;
		case (w.func)
			FUNC_GET: begin
				r.status = ST_ABSENT;
				if (w.prop_id != RESERVED_ID) begin
					for (int i = 0; i < prim_fill[s]; i++)
						if (!hit && prim_ids[s][i] == w.prop_id) begin
							r.read_value = prim_vals[s][i];
							hit = 1'b1;
						end
					for (int i = 0; i < spill_fill[s]; i++)
						if (!hit && spill_ids[s][i] == w.prop_id) begin
							r.read_value = spill_vals[s][i];
							hit = 1'b1;
						end
					if (hit)
						r.status = ST_OK;
				end
			end
			FUNC_SET: begin
				r.status = ST_DROPPED;
				if (w.prop_id != RESERVED_ID) begin
					for (int i = 0; i < prim_fill[s]; i++)
						if (!hit && prim_ids[s][i] == w.prop_id) begin
							prim_vals[s][i] = w.write_value;
							hit = 1'b1;
						end
					for (int i = 0; i < spill_fill[s]; i++)
						if (!hit && spill_ids[s][i] == w.prop_id) begin
							spill_vals[s][i] = w.write_value;
							hit = 1'b1;
						end
					if (!hit && prim_fill[s] < PWAYS) begin
						prim_ids[s][prim_fill[s]] = w.prop_id;
						prim_vals[s][prim_fill[s]] = w.write_value;
						prim_fill[s]++;
						hit = 1'b1;
					end else if (!hit && spill_fill[s] < SWAYS) begin
						spill_ids[s][spill_fill[s]] = w.prop_id;
						spill_vals[s][spill_fill[s]] = w.write_value;
						spill_fill[s]++;
						hit = 1'b1;
					end
					if (hit)
						r.status = ST_OK;
				end
			end
			FUNC_ALLOC: begin
				if (free_top > 0) begin
					free_top--;
					s = free_slots[free_top];
					got = 1'b1;
				end else if (fresh_next < SLOTS) begin
					s = fresh_next;
					fresh_next++;
					got = 1'b1;
				end
				if (got) begin
					prim_fill[s] = 0;
					spill_fill[s] = 0;
					live_count++;
					r.slot_out = s[7:0];
				end else begin
					r.slot_out = '0;
					r.status = ST_NO_SLOT;
				end
			end
			default: begin
				if (live_count > 0 && free_top < SLOTS) begin
					prim_fill[s] = 0;
					spill_fill[s] = 0;
					free_slots[free_top] = w.slot;
					free_top++;
					live_count--;
				end
			end
		endcase
		r.live_slots = live_count[8:0];
		return r;
	endfunction

	// send one request word after a random gap, or with no gap while no_idle is set
	task automatic send_word(req_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_store(w));
	endtask

	task automatic send_req(logic [1:0] f, logic [7:0] s, logic [15:0] pid,
			logic [31:0] val, logic [15:0] ent);
		req_t w;
		w.func = f;
		w.slot = s;
		w.prop_id = pid;
		w.write_value = val;
		w.entity_id = ent;
		send_word(w);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() > 0)
			@(posedge clk);
	endtask

	// check responses and draw receiver stalls
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word %h", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.read_value !== want.read_value || rsp.slot_out !== want.slot_out ||
						rsp.status !== want.status || rsp.live_slots !== want.live_slots) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"response mismatch: value %0d/%0d slot %0d/%0d ",
							"status %0d/%0d live %0d/%0d (exp/act)"},
							want.read_value, rsp.read_value, want.slot_out, rsp.slot_out,
							want.status, rsp.status, want.live_slots, rsp.live_slots);
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 3);
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// empty store: free with nothing live, lookups and reserved id
	task automatic test_empty_store();
		send_req(FUNC_FREE, 8'd5, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_GET, 8'd0, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_GET, 8'd255, 16'd65534, 32'd0, 16'd0);
		send_req(FUNC_SET, 8'd9, RESERVED_ID, 32'h7fffffff, 16'd0);
		send_req(FUNC_GET, 8'd9, RESERVED_ID, 32'd0, 16'd0);
	endtask

	// fill primary then spill row, overflow, update and read back, then free and reuse slots
	task automatic test_row_overflow();
		send_req(FUNC_ALLOC, 8'd0, 16'd0, 32'd0, 16'hffff);
		send_req(FUNC_ALLOC, 8'd0, 16'd0, 32'd0, 16'd0);
		for (int i = 0; i < PWAYS + SWAYS + 1; i++)
			send_req(FUNC_SET, 8'd0, 16'(i * 4093), 32'(i) ^ 32'h80000000, 16'd0);
		send_req(FUNC_SET, 8'd0, 16'(15 * 4093), 32'h7fffffff, 16'd0);
		send_req(FUNC_SET, 8'd0, 16'd0, 32'hffffffff, 16'd0);
		send_req(FUNC_GET, 8'd0, 16'(15 * 4093), 32'd0, 16'd0);
		send_req(FUNC_GET, 8'd0, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_GET, 8'd0, 16'(16 * 4093), 32'd0, 16'd0);
		send_req(FUNC_SET, 8'd200, 16'd7, 32'd1, 16'd0);
		send_req(FUNC_GET, 8'd200, 16'd7, 32'd0, 16'd0);
		send_req(FUNC_FREE, 8'd0, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_GET, 8'd0, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_FREE, 8'd200, 16'd0, 32'd0, 16'd0);
		send_req(FUNC_ALLOC, 8'd0, 16'd0, 32'd0, 16'h1234);
		send_req(FUNC_GET, 8'd200, 16'd7, 32'd0, 16'd0);
	endtask

	// hand out every slot, allocate with none left, then free at random among the low slots
	task automatic test_slot_exhaustion();
		no_idle = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			send_req(FUNC_ALLOC, 8'd0, 16'd0, 32'd0, 16'($urandom));
		send_req(FUNC_ALLOC, 8'd0, 16'd0, 32'd0, 16'd77);
		for (int i = 0; i < SLOTS / 2; i++)
			send_req(FUNC_FREE, 8'($urandom_range(0, 31)), 16'd0, 32'd0, 16'd0);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// random requests over a few hot slots and ids
	task automatic test_random_mix(int count);
		req_t w;
		int   pick;
		for (int n = 0; n < count; n++) begin
			no_idle = ((n / 100) % 4) == 1;
			if (n == count / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			w.func = pick < 40 ? FUNC_GET : pick < 80 ? FUNC_SET :
				pick < 90 ? FUNC_ALLOC : FUNC_FREE;
			w.slot = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom);
			pick = $urandom_range(0, 99);
			w.prop_id = pick < 80 ? 16'($urandom_range(0, 23)) :
				pick < 97 ? 16'($urandom_range(0, 65534)) : RESERVED_ID;
			w.write_value = $urandom;
			w.entity_id = $urandom;
			send_word(w);
		end
	endtask

	initial begin
		free_top = 0;
		fresh_next = 0;
		live_count = 0;
		for (int i = 0; i < SLOTS; i++) begin
			prim_fill[i] = 0;
			spill_fill[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_store();
		test_row_overflow();
		test_slot_exhaustion();
		test_random_mix(780);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/sps_pkg.sv
hdl/slot_property_store_unit.sv
hdl/sps_check.sv
tb/sv/slot_property_store_unit_test.sv
